@@ rtl/core/hbos_pkg.sv @@
// Package for the hierarchical bitmap ordered set: sizes, opcodes and the
// bit-search helpers used by the sequencer.
// No dependencies.
`default_nettype none

package hbos_pkg;

    localparam int KEY_BITS       = 18;
    localparam int WORD_LG        = 6;
    localparam int WORD_BITS      = 1 << WORD_LG;
    localparam int LEAF_ADDR_BITS = KEY_BITS - WORD_LG;
    localparam int MID_ADDR_BITS  = KEY_BITS - 2 * WORD_LG;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WORD_LG-1:0]   t_pos;
    typedef logic [KEY_BITS-1:0]  t_key;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SUCC   = 2'd2,
        OP_PRED   = 2'd3
    } t_op;

    // Position of the lowest set bit; zero for an empty word.
    function automatic t_pos f_lowest(input t_word v);
        t_pos r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = t_pos'(i);
        end
        return r;
    endfunction

    // Position of the highest set bit; zero for an empty word.
    function automatic t_pos f_highest(input t_word v);
        t_pos r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) r = t_pos'(i);
        end
        return r;
    endfunction

    // Bits strictly above the given position.
    function automatic t_word f_above(input t_pos p);
        return ~((t_word'(2) << p) - t_word'(1));
    endfunction

    // Bits strictly below the given position.
    function automatic t_word f_below(input t_pos p);
        return (t_word'(1) << p) - t_word'(1);
    endfunction

    // Lowest set bit for successor searches, highest for predecessor ones.
    function automatic t_pos f_pick(input t_word v, input logic succ);
        return succ ? f_lowest(v) : f_highest(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/hierarchical_bitmap_ordered_set.sv @@
// Top level of the hierarchical bitmap ordered set: sequencer, summary
// register and the two word memories. Depends on hbos_pkg and hbos_ram.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  request   in         i_in_valid / o_in_ready   i_opcode, i_key
//  result    out        o_out_valid / i_out_ready o_found, o_result_key
// ----------------------------------------------------------------------------
// Insert and delete finish in S_EVAL; a successor or predecessor query
// finishes in S_EVAL, in S_LEAF after S_EVAL, or in S_LEAF after S_MID, set by the chain
// of dependent reads through the middle and leaf memories (one read each per
// cycle, registered read data).
// Reset clears only the sequencer, the output valid flag and the top summary word. There is no
// clearing pass: a middle word counts as zero while its top bit is clear,
// and a leaf word while its middle bit is clear, so stale memory contents
// are never seen.
// A finished result waits in the output register; the next request is
// still taken and held back only at the point where it needs that register.
`default_nettype none

module hierarchical_bitmap_ordered_set
    import hbos_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [KEY_BITS-1:0] i_key,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_found,
    output logic [KEY_BITS-1:0]      o_result_key
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MID,
        S_LEAF,
        S_PUSH
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_key   r_key, n_key;
    t_word  r_top, n_top;
    // Middle index of a descent, then the leaf address it settles on.
    logic [MID_ADDR_BITS-1:0]  r_hi, n_hi;
    logic [LEAF_ADDR_BITS-1:0] r_base, n_base;
    // A result that found the output register still occupied.
    logic r_pend_found, n_pend_found;
    t_key r_pend_key, n_pend_key;
    logic r_out_valid, n_out_valid;
    logic r_out_found, n_out_found;
    t_key r_out_key, n_out_key;

    // Memory ports.
    logic                      leaf_we, mid_we;
    logic [LEAF_ADDR_BITS-1:0] leaf_raddr;
    logic [MID_ADDR_BITS-1:0]  mid_raddr;
    t_word                     leaf_wdata, mid_wdata, leaf_rd, mid_rd;

    // Evaluation of the three words touched by the request key.
    t_pos  k0, k1, k2;
    t_word mid_w, leaf_w, cand0, cand1, cand2, new_leaf, new_mid;
    logic  succ, is_update, out_free;
    t_pos  q1;

    // Result produced this cycle.
    logic done;
    logic res_found;
    t_key res_key;
    logic load_out;

    hbos_ram #(
        .ADDR_BITS(LEAF_ADDR_BITS),
        .DATA_BITS(WORD_BITS)
    ) u_leaf (
        .i_clk  (i_clk),
        .i_we   (leaf_we),
        .i_waddr(r_key[KEY_BITS-1:WORD_LG]),
        .i_wdata(leaf_wdata),
        .i_raddr(leaf_raddr),
        .o_rdata(leaf_rd)
    );

    hbos_ram #(
        .ADDR_BITS(MID_ADDR_BITS),
        .DATA_BITS(WORD_BITS)
    ) u_mid (
        .i_clk  (i_clk),
        .i_we   (mid_we),
        .i_waddr(r_key[KEY_BITS-1:2*WORD_LG]),
        .i_wdata(mid_wdata),
        .i_raddr(mid_raddr),
        .o_rdata(mid_rd)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_result_key = r_out_key;
    assign out_free     = !r_out_valid || i_out_ready;

    always_comb begin
        k0 = r_key[WORD_LG-1:0];
        k1 = r_key[2*WORD_LG-1:WORD_LG];
        k2 = r_key[KEY_BITS-1:2*WORD_LG];
        succ      = (r_op == OP_SUCC);
        is_update = r_op inside {OP_INSERT, OP_DELETE};

        // A word is only trusted when its summary bit one level up is set.
        mid_w  = r_top[k2] ? mid_rd : '0;
        leaf_w = mid_w[k1] ? leaf_rd : '0;

        cand0 = leaf_w & (succ ? f_above(k0) : f_below(k0));
        cand1 = mid_w  & (succ ? f_above(k1) : f_below(k1));
        cand2 = r_top  & (succ ? f_above(k2) : f_below(k2));

        if (r_op == OP_INSERT) begin
            new_leaf = leaf_w | (t_word'(1) << k0);
            new_mid  = mid_w  | (t_word'(1) << k1);
        end else begin
            new_leaf = leaf_w & ~(t_word'(1) << k0);
            new_mid  = (new_leaf == '0) ? (mid_w & ~(t_word'(1) << k1)) : mid_w;
        end
        q1 = f_pick(mid_rd, succ);
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_top        = r_top;
        n_hi         = r_hi;
        n_base       = r_base;
        n_pend_found = r_pend_found;
        n_pend_key   = r_pend_key;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_key    = r_out_key;

        leaf_we    = 1'b0;
        mid_we     = 1'b0;
        leaf_wdata = new_leaf;
        mid_wdata  = new_mid;
        leaf_raddr = r_key[KEY_BITS-1:WORD_LG];
        mid_raddr  = k2;

        done      = 1'b0;
        res_found = 1'b0;
        res_key   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Both words under the key are fetched together.
                leaf_raddr = i_key[KEY_BITS-1:WORD_LG];
                mid_raddr  = i_key[KEY_BITS-1:2*WORD_LG];
                if (i_in_valid) begin
                    n_op    = t_op'(i_opcode);
                    n_key   = i_key;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (is_update) begin
                    leaf_we = 1'b1;
                    mid_we  = 1'b1;
                    if (r_op == OP_INSERT) begin
                        n_top[k2] = 1'b1;
                    end else if (new_mid == '0) begin
                        n_top[k2] = 1'b0;
                    end
                    done      = 1'b1;
                    res_found = leaf_w[k0];
                    res_key   = r_key;
                end else if (cand0 != '0) begin
                    done      = 1'b1;
                    res_found = 1'b1;
                    res_key   = {k2, k1, f_pick(cand0, succ)};
                end else if (cand1 != '0) begin
                    // Neighbour lies in another leaf word of the same middle word.
                    leaf_raddr = {k2, f_pick(cand1, succ)};
                    n_base     = {k2, f_pick(cand1, succ)};
                    n_state    = S_LEAF;
                end else if (cand2 != '0) begin
                    mid_raddr = f_pick(cand2, succ);
                    n_hi      = f_pick(cand2, succ);
                    n_state   = S_MID;
                end else begin
                    done = 1'b1;
                end
            end
            S_MID: begin
                leaf_raddr = {r_hi, q1};
                n_base     = {r_hi, q1};
                n_state    = S_LEAF;
            end
            S_LEAF: begin
                done      = 1'b1;
                res_found = 1'b1;
                res_key   = {r_base, f_pick(leaf_rd, succ)};
            end
            S_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_pend_found;
                    n_out_key   = r_pend_key;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        load_out = done && out_free;
        if (done) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_found = res_found;
                n_out_key   = res_key;
                n_state     = S_IDLE;
            end else begin
                n_pend_found = res_found;
                n_pend_key   = res_key;
                n_state      = S_PUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_hi         <= n_hi;
        r_base       <= n_base;
        r_pend_found <= n_pend_found;
        r_pend_key   <= n_pend_key;
        r_out_found  <= n_out_found;
        r_out_key    <= n_out_key;
    end

    // A successor found lies strictly above the request key.
    a_succ_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_op == OP_SUCC && res_found) |-> (res_key > r_key))
        else $error("successor not above key");

    // A predecessor found lies strictly below the request key.
    a_pred_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_op == OP_PRED && res_found) |-> (res_key < r_key))
        else $error("predecessor not below key");

    // Updates echo their key.
    a_update_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && is_update) |-> (res_key == r_key))
        else $error("update result key differs from request key");

    // A result that is loaded shows up on the output in the next cycle.
    a_load_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_out_valid && o_result_key == $past(res_key)))
        else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ rtl/core/hbos_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Depends on hbos_pkg for its default sizes.
`default_nettype none

module hbos_ram
    import hbos_pkg::*;
#(
    parameter int ADDR_BITS = LEAF_ADDR_BITS,
    parameter int DATA_BITS = WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [(1 << ADDR_BITS)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for hierarchical_bitmap_ordered_set: drives insert, delete,
// successor and predecessor requests and checks every result against a behavioural
// model of the three-level bitmap tree. Depends on hbos_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench
    import hbos_pkg::*;
();

    localparam int   KEY_MAX       = (1 << KEY_BITS) - 1;
    localparam int   LEAF_COUNT    = 1 << LEAF_ADDR_BITS;
    localparam int   MID_COUNT     = 1 << MID_ADDR_BITS;
    // Cycles without a single transfer on either channel before the run is abandoned.
    localparam int   IDLE_LIMIT    = 5000;
    // Allow a generous margin after the last result.
    localparam int   SETTLE_CYCLES = 16;
    localparam int   LONG_HOLD     = 300;
    localparam int   PRINT_CAP     = 40;

    // What one request should produce, kept together with the request for reporting.
    typedef struct packed {
        t_op  op;
        t_key key;
        logic found;
        t_key result_key;
    } t_set_answer;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_opcode     = OP_INSERT;
    t_key        i_key        = '0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    t_key        o_result_key;

    hierarchical_bitmap_ordered_set dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_result_key (o_result_key)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioural model of the set. The three levels mirror the block:
    // leaf words hold one bit per key, middle words one bit per nonzero
    // leaf word, and the single top word one bit per nonzero middle word.
    // ------------------------------------------------------------------
    t_word       leaf_words [LEAF_COUNT];
    t_word       mid_words  [MID_COUNT];
    t_word       top_word;

    t_set_answer pending_answers [$];
    t_key        member_pool [$];   // recently inserted keys, used to aim deletes and queries
    t_key        hot_base;

    int          mismatch_count = 0;
    int          requests_by_op [4];
    int          climb_hits [3];    // queries answered at each level of the climb
    int          idle_cycles = 0;

    logic        source_idle_en = 1'b0;
    logic        sink_idle_en   = 1'b0;
    int          hold_off_cycles = 0;

    function automatic int lowest_set(input t_word v);
        int p;
        p = 0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (v[b]) p = b;
        end
        return p;
    endfunction

    function automatic int highest_set(input t_word v);
        int p;
        p = 0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (v[b]) p = b;
        end
        return p;
    endfunction

    function automatic t_word read_level(input int lvl, input int idx);
        if (lvl == 0) return leaf_words[idx % LEAF_COUNT];
        if (lvl == 1) return mid_words[idx % MID_COUNT];
        return top_word;
    endfunction

    function automatic void write_level(input int lvl, input int idx, input t_word v);
        if (lvl == 0) leaf_words[idx % LEAF_COUNT] = v;
        else if (lvl == 1) mid_words[idx % MID_COUNT] = v;
        else top_word = v;
    endfunction

    // Applies one request to the model and returns the result the block should give.
    function automatic t_set_answer apply_request(input t_op op, input t_key key);
        t_set_answer ans;
        t_word       w;
        t_word       cand;
        int          idx;
        int          pos;
        int          p;
        int          neighbour;
        logic        done;
        ans.op         = op;
        ans.key        = key;
        ans.found      = 1'b0;
        ans.result_key = '0;
        done           = 1'b0;
        if (op == OP_INSERT || op == OP_DELETE) begin
            w              = read_level(0, int'(key) >> WORD_LG);
            ans.found      = w[key[WORD_LG-1:0]];
            ans.result_key = key;
            // Walk upwards; an insert stops at a bit already set, a delete
            // stops as soon as a word keeps another member.
            for (int lvl = 0; lvl < 3; lvl++) begin
                if (!done) begin
                    idx = int'(key) >> (WORD_LG * (lvl + 1));
                    pos = (int'(key) >> (WORD_LG * lvl)) & (WORD_BITS - 1);
                    w   = read_level(lvl, idx);
                    if (op == OP_INSERT) begin
                        if (w[pos]) begin
                            done = 1'b1;
                        end else begin
                            w[pos] = 1'b1;
                            write_level(lvl, idx, w);
                        end
                    end else begin
                        w[pos] = 1'b0;
                        write_level(lvl, idx, w);
                        if (w != '0) done = 1'b1;
                    end
                end
            end
            if (op == OP_INSERT && !ans.found) begin
                member_pool.insert(member_pool.size(), key);
                if (member_pool.size() > 256) void'(member_pool.pop_front());
            end
        end else begin
            for (int lvl = 0; lvl < 3; lvl++) begin
                if (!done) begin
                    idx = int'(key) >> (WORD_LG * (lvl + 1));
                    pos = (int'(key) >> (WORD_LG * lvl)) & (WORD_BITS - 1);
                    w   = read_level(lvl, idx);
                    if (op == OP_SUCC) begin
                        cand = (pos == WORD_BITS - 1) ? t_word'(0) : (w >> (pos + 1));
                    end else begin
                        cand = w & ((t_word'(1) << pos) - t_word'(1));
                    end
                    if (cand != '0) begin
                        p = (op == OP_SUCC) ? lowest_set(cand) + pos + 1 : highest_set(cand);
                        neighbour = (idx << (WORD_LG * (lvl + 1))) + (p << (WORD_LG * lvl));
                        // Descend to the leaf, taking the nearest member at each level.
                        for (int j = lvl - 1; j >= 0; j--) begin
                            w = read_level(j, neighbour >> (WORD_LG * (j + 1)));
                            p = (op == OP_SUCC) ? lowest_set(w) : highest_set(w);
                            neighbour += p << (WORD_LG * j);
                        end
                        ans.found      = 1'b1;
                        ans.result_key = t_key'(neighbour);
                        climb_hits[lvl]++;
                        done = 1'b1;
                    end
                end
            end
        end
        requests_by_op[op]++;
        return ans;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_INSERT;
        if (r < 55) return OP_DELETE;
        if (r < 78) return OP_SUCC;
        return OP_PRED;
    endfunction

    // Keys cluster round a moving base so that words fill up and queries find
    // near neighbours, with known members and fully random keys mixed in.
    function automatic t_key pick_key();
        int r;
        t_key k;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            k = t_key'(hot_base + $urandom_range(0, 127));
        end else if (r < 55) begin
            k = t_key'(hot_base + $urandom_range(0, 8191));
        end else if (r < 75 && member_pool.size() != 0) begin
            k = member_pool[$urandom_range(0, member_pool.size() - 1)];
            if ($urandom_range(0, 3) == 0) k = t_key'(k + $urandom_range(0, 2) - 1);
        end else begin
            k = t_key'($urandom);
        end
        return k;
    endfunction

    function automatic void move_hot_base();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) hot_base = '0;
        else if (r == 1) hot_base = t_key'(KEY_MAX - 255);
        else hot_base = t_key'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input t_set_answer want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch, %s: op %s key %0d, expected found %0b key %0d, got %0b %0d",
                     $realtime, what, want.op.name(), want.key, want.found, want.result_key,
                     o_found, o_result_key);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side. The payload is set with valid and held until the
    // transfer; the expectation is recorded at the edge of the transfer.
    // ------------------------------------------------------------------
    task automatic send_request(input t_op op, input t_key key);
        int gap;
        gap = source_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers.insert(pending_answers.size(), apply_request(op, key));
    endtask

    // The sender stops offering and waits for every outstanding result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: the ready pattern comes from its own process, so that
    // stalls fall independently of the requests. A long hold-off is asked
    // for by setting hold_off_cycles and is counted out here.
    // ------------------------------------------------------------------
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                n               = hold_off_cycles;
                hold_off_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (!sink_idle_en) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Each result transfer is compared with the oldest outstanding expectation.
    t_set_answer head_answer;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                head_answer = '0;
                report_mismatch("result with nothing outstanding", head_answer);
            end else begin
                head_answer = pending_answers.pop_front();
                if (o_found !== head_answer.found)
                    report_mismatch("found flag", head_answer);
                if (o_result_key !== head_answer.result_key)
                    report_mismatch("result key", head_answer);
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer at all means the block is stuck.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edges of the key range, word and middle-word boundaries, repeated
    // inserts, absent deletes and searches that find nothing.
    task automatic test_directed_edges();
        send_request(OP_SUCC,   t_key'(0));        // empty set: no successor
        send_request(OP_PRED,   t_key'(KEY_MAX));  // empty set: no predecessor
        send_request(OP_INSERT, t_key'(0));
        send_request(OP_INSERT, t_key'(0));        // already present
        send_request(OP_INSERT, t_key'(KEY_MAX));
        send_request(OP_SUCC,   t_key'(0));        // climbs to the top word
        send_request(OP_PRED,   t_key'(KEY_MAX));
        send_request(OP_SUCC,   t_key'(KEY_MAX));  // nothing above the largest key
        send_request(OP_PRED,   t_key'(0));        // nothing below key zero
        send_request(OP_INSERT, t_key'(63));
        send_request(OP_INSERT, t_key'(64));
        send_request(OP_SUCC,   t_key'(63));       // crosses a leaf word boundary
        send_request(OP_PRED,   t_key'(64));
        send_request(OP_INSERT, t_key'(4095));
        send_request(OP_INSERT, t_key'(4096));
        send_request(OP_PRED,   t_key'(4096));     // crosses a middle word boundary
        send_request(OP_SUCC,   t_key'(4095));
        send_request(OP_DELETE, t_key'(5));        // absent key
        send_request(OP_DELETE, t_key'(64));
        send_request(OP_SUCC,   t_key'(63));
        send_request(OP_DELETE, t_key'(0));
        send_request(OP_DELETE, t_key'(63));
        send_request(OP_DELETE, t_key'(4095));
        send_request(OP_DELETE, t_key'(4096));
        send_request(OP_DELETE, t_key'(KEY_MAX));  // set is empty again
        wait_drained();
    endtask

    // Bulk random traffic with gaps on both channels.
    task automatic test_random_traffic(input int count);
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 48 == 0) move_hot_base();
            send_request(pick_op(), pick_key());
        end
        wait_drained();
    endtask

    // The bench offers requests and takes results with no idle gaps on either channel.
    task automatic test_steady_stream(input int count);
        source_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0) move_hot_base();
            send_request(pick_op(), pick_key());
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills up and must stall its input; then the sender pauses
    // until every result has been taken.
    task automatic test_backpressure(input int count);
        source_idle_en  = 1'b0;
        sink_idle_en    = 1'b1;
        hold_off_cycles = LONG_HOLD;
        for (int n = 0; n < count; n++) begin
            send_request(pick_op(), pick_key());
        end
        wait_drained();
    endtask

    initial begin
        top_word = '0;
        foreach (leaf_words[n]) leaf_words[n] = '0;
        foreach (mid_words[n]) mid_words[n] = '0;
        foreach (requests_by_op[n]) requests_by_op[n] = 0;
        foreach (climb_hits[n]) climb_hits[n] = 0;
        hot_base = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_traffic(450);
        test_backpressure(40);
        test_steady_stream(120);
        test_random_traffic(340);

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Requests: %0d insert, %0d delete, %0d successor, %0d predecessor;",
                 requests_by_op[OP_INSERT], requests_by_op[OP_DELETE],
                 requests_by_op[OP_SUCC], requests_by_op[OP_PRED]);
        $display("searches answered in the leaf, middle and top words: %0d, %0d, %0d.",
                 climb_hits[0], climb_hits[1], climb_hits[2]);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/hbos_pkg.sv
rtl/core/hbos_ram.sv
rtl/core/hierarchical_bitmap_ordered_set.sv
tb/testbench.sv
